[rtl/gbn_pkg.sv]
// Package for the go-back-n sender: constants, codes, sequencer states.
// No dependencies.
package gbn_pkg;

  localparam int WINDOW_MAX_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [31:0] ACK_FILLER = 32'd123;

  typedef enum logic [1:0] {
    OP_MSG   = 2'd0,
    OP_ACK   = 2'd1,
    OP_TIMER = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_ACK_CHK,
    ST_ACK_STOP,
    ST_ACK_START,
    ST_TRY,
    ST_LOAD,
    ST_FRAME,
    ST_SEND,
    ST_SEND_START,
    ST_TO_READ,
    ST_TO_SEND,
    ST_TO_START
  } state_t;

endpackage

[rtl/go_back_n_sender_unit.sv]
// Go-back-n sender top level: message queue, window store, sequencer.
// Depends on gbn_pkg.
//
// Usage:
// - Input channel (in_valid/in_stall): one item is a message (operation 0),
//   an arriving acknowledgement packet (1) or a retransmit timeout (2).
// - Output channel (out_valid/out_stall): result items, each a packet send or
//   a timer start/stop command; last marks the final result of an input item.
// - APB port: register 0 at address 0 is window_limit (4 bits, reset 8).
// - One shared 32-bit adder builds every checksum: it takes one payload byte
//   per cycle, all 20 bytes, then the sequence and ack fields.
// - Order: a message's packet is framed and summed before its send; an ack is
//   summed and checked before its stop command, and a send may follow it; a
//   timeout resends each packet in the window, then issues a timer start.
// - The block takes one item at a time: in_stall stays high from accept until
//   the last result of that item has been taken.
// - A result is held on the outputs until out_stall is low; the
//   sequencer waits there, nothing is lost or repeated.
// - Reset clears queue and window counts, timer flag and sequence number;
//   stored payloads need no clearing since only filled entries are read.
module go_back_n_sender_unit #(
  parameter int WINDOW_MAX  = gbn_pkg::WINDOW_MAX_DEF,
  parameter int QUEUE_DEPTH = gbn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] payload_low,
  input  logic [63:0] payload_mid,
  input  logic [31:0] payload_top,
  input  logic [31:0] packet_seq,
  input  logic [31:0] packet_ack,
  input  logic [31:0] packet_check,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [63:0] out_payload_low,
  output logic [63:0] out_payload_mid,
  output logic [31:0] out_payload_top,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [31:0] out_check,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QF = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WF = $clog2(WINDOW_MAX + 1);
  localparam int LW = (WF > 4) ? WF : 4;

  // ---------------- configuration
  logic [3:0] window_limit;
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {28'd0, window_limit} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= 4'd8;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      window_limit <= pwdata[3:0];
    end
  end

  // effective limit: 0 -> 1, clamp at WINDOW_MAX
  logic [LW-1:0] lim_raw, eff_limit;
  always_comb begin
    lim_raw = LW'(window_limit);
    if (lim_raw == '0) eff_limit = LW'(1);
    else if (lim_raw > LW'(WINDOW_MAX)) eff_limit = LW'(WINDOW_MAX);
    else eff_limit = lim_raw;
  end

  // ---------------- memories
  logic [159:0] queue_mem [QUEUE_DEPTH];
  logic [159:0] win_pay   [WINDOW_MAX];
  logic [31:0]  win_seq   [WINDOW_MAX];
  logic [31:0]  win_check [WINDOW_MAX];

  // ---------------- state
  gbn_pkg::state_t state, state_next;
  logic [QW-1:0] queue_read, queue_write;
  logic [QF-1:0] queue_fill;
  logic [WW-1:0] win_oldest, win_next;
  logic [WF-1:0] win_fill;
  logic          timer_running;
  logic [31:0]   next_sequence;

  logic [1:0]    op;
  logic [159:0]  work;        // payload being summed, shifted a byte a step
  logic [159:0]  pkt;         // packet payload held for framing
  logic [31:0]   acc;
  logic [4:0]    byte_cnt;
  logic [1:0]    sum_step;    // 0: bytes, 1: +seq, 2: +ack, 3: done
  logic [31:0]   add_b;
  logic [31:0]   hold_seq, hold_ack, hold_chk;
  logic [WF-1:0] to_cnt;
  logic [WW-1:0] to_slot;
  logic [159:0]  rd_pay;
  logic [31:0]   rd_seq, rd_chk, rd_oseq;

  logic in_acc, out_fire, sum_done;
  assign in_stall = (state != gbn_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // the shared adder
  always_comb begin
    case (sum_step)
      2'd0:    add_b = {24'd0, work[7:0]};
      2'd1:    add_b = hold_seq;
      default: add_b = hold_ack;
    endcase
  end
  assign sum_done = (sum_step == 2'd3);

  function automatic logic [WW-1:0] wnext(input logic [WW-1:0] s);
    if (32'(s) == WINDOW_MAX - 1) return '0;
    return s + WW'(1);
  endfunction
  function automatic logic [QW-1:0] qnext(input logic [QW-1:0] s);
    if (32'(s) == QUEUE_DEPTH - 1) return '0;
    return s + QW'(1);
  endfunction

  logic can_send;
  assign can_send = (queue_fill != '0) && (LW'(win_fill) < eff_limit);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gbn_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (operation)
            gbn_pkg::OP_MSG:   state_next = gbn_pkg::ST_TRY;
            gbn_pkg::OP_ACK:   state_next = (win_fill == '0) ? gbn_pkg::ST_IDLE
                                                              : gbn_pkg::ST_SUM;
            gbn_pkg::OP_TIMER: state_next = gbn_pkg::ST_TO_READ;
            default:           state_next = gbn_pkg::ST_IDLE;
          endcase
        end
      end
      gbn_pkg::ST_SUM: begin
        if (sum_done) begin
          state_next = (op == gbn_pkg::OP_ACK) ? gbn_pkg::ST_ACK_CHK
                                               : gbn_pkg::ST_SEND;
        end
      end
      gbn_pkg::ST_ACK_CHK: begin
        state_next = (acc == hold_chk && hold_ack == rd_oseq)
                     ? gbn_pkg::ST_ACK_STOP : gbn_pkg::ST_IDLE;
      end
      gbn_pkg::ST_ACK_STOP: begin
        if (out_fire) begin
          state_next = (win_fill != '0) ? gbn_pkg::ST_ACK_START : gbn_pkg::ST_TRY;
        end
      end
      gbn_pkg::ST_ACK_START: if (out_fire) state_next = gbn_pkg::ST_TRY;
      gbn_pkg::ST_TRY: begin
        state_next = can_send ? gbn_pkg::ST_LOAD : gbn_pkg::ST_IDLE;
      end
      gbn_pkg::ST_LOAD:  state_next = gbn_pkg::ST_FRAME;
      gbn_pkg::ST_FRAME: state_next = gbn_pkg::ST_SUM;
      gbn_pkg::ST_SEND: begin
        if (out_fire) begin
          state_next = timer_running ? gbn_pkg::ST_IDLE : gbn_pkg::ST_SEND_START;
        end
      end
      gbn_pkg::ST_SEND_START: if (out_fire) state_next = gbn_pkg::ST_IDLE;
      gbn_pkg::ST_TO_READ: begin
        state_next = (to_cnt < win_fill) ? gbn_pkg::ST_TO_SEND : gbn_pkg::ST_TO_START;
      end
      gbn_pkg::ST_TO_SEND:  if (out_fire) state_next = gbn_pkg::ST_TO_READ;
      gbn_pkg::ST_TO_START: if (out_fire) state_next = gbn_pkg::ST_IDLE;
      default: state_next = gbn_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid       = 1'b0;
    action          = gbn_pkg::ACT_SEND;
    out_payload_low = '0;
    out_payload_mid = '0;
    out_payload_top = '0;
    out_seq         = '0;
    out_ack         = '0;
    out_check       = '0;
    last            = 1'b0;
    case (state)
      gbn_pkg::ST_ACK_STOP: begin
        out_valid = 1'b1;
        action    = gbn_pkg::ACT_STOP;
        last      = (win_fill == '0) && !can_send;
      end
      gbn_pkg::ST_ACK_START: begin
        out_valid = 1'b1;
        action    = gbn_pkg::ACT_START;
        last      = !can_send;
      end
      gbn_pkg::ST_SEND: begin
        out_valid       = 1'b1;
        {out_payload_top, out_payload_mid, out_payload_low} = pkt;
        out_seq         = hold_seq;
        out_ack         = gbn_pkg::ACK_FILLER;
        out_check       = acc;
        last            = timer_running;
      end
      gbn_pkg::ST_TO_SEND: begin
        out_valid       = 1'b1;
        {out_payload_top, out_payload_mid, out_payload_low} = rd_pay;
        out_seq         = rd_seq;
        out_ack         = gbn_pkg::ACK_FILLER;
        out_check       = rd_chk;
      end
      gbn_pkg::ST_SEND_START, gbn_pkg::ST_TO_START: begin
        out_valid = 1'b1;
        action    = gbn_pkg::ACT_START;
        last      = 1'b1;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (in_acc && operation == gbn_pkg::OP_MSG && 32'(queue_fill) < QUEUE_DEPTH) begin
      queue_mem[queue_write] <= {payload_top, payload_mid, payload_low};
    end
    if (state == gbn_pkg::ST_TRY) pkt <= queue_mem[queue_read];
    if (state == gbn_pkg::ST_SEND && out_fire) begin
      win_pay[win_next]   <= pkt;
      win_seq[win_next]   <= hold_seq;
      win_check[win_next] <= acc;
    end
    rd_oseq <= win_seq[win_oldest];
    rd_pay  <= win_pay[to_slot];
    rd_seq  <= win_seq[to_slot];
    rd_chk  <= win_check[to_slot];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op       <= operation;
      work     <= {payload_top, payload_mid, payload_low};
      hold_seq <= packet_seq;
      hold_ack <= packet_ack;
      hold_chk <= packet_check;
      acc      <= '0;
      byte_cnt <= '0;
      sum_step <= 2'd0;
      to_slot  <= win_oldest;
      to_cnt   <= '0;
    end
    case (state)
      gbn_pkg::ST_FRAME: begin
        op       <= gbn_pkg::OP_MSG;
        work     <= pkt;
        hold_seq <= next_sequence;
        hold_ack <= gbn_pkg::ACK_FILLER;
        acc      <= '0;
        byte_cnt <= '0;
        sum_step <= 2'd0;
      end
      gbn_pkg::ST_SUM: begin
        if (!sum_done) begin
          acc <= acc + add_b;
          if (sum_step == 2'd0) begin
            work     <= work >> 8;
            byte_cnt <= byte_cnt + 5'd1;
            if (byte_cnt == 5'd19) sum_step <= 2'd1;
          end else begin
            sum_step <= sum_step + 2'd1;
          end
        end
      end
      gbn_pkg::ST_TO_SEND: begin
        if (out_fire) begin
          to_slot <= wnext(to_slot);
          to_cnt  <= to_cnt + WF'(1);
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gbn_pkg::ST_IDLE;
      queue_read    <= '0;
      queue_write   <= '0;
      queue_fill    <= '0;
      win_oldest    <= '0;
      win_next      <= '0;
      win_fill      <= '0;
      timer_running <= 1'b0;
      next_sequence <= '0;
    end else begin
      state <= state_next;
      if (in_acc && operation == gbn_pkg::OP_MSG && 32'(queue_fill) < QUEUE_DEPTH) begin
        queue_write <= qnext(queue_write);
        queue_fill  <= queue_fill + QF'(1);
      end
      if (state == gbn_pkg::ST_ACK_CHK && state_next == gbn_pkg::ST_ACK_STOP) begin
        win_fill   <= win_fill - WF'(1);
        win_oldest <= wnext(win_oldest);
      end
      if (state == gbn_pkg::ST_ACK_STOP && out_fire) timer_running <= 1'b0;
      if ((state == gbn_pkg::ST_ACK_START || state == gbn_pkg::ST_SEND_START ||
           state == gbn_pkg::ST_TO_START) && out_fire) begin
        timer_running <= 1'b1;
      end
      if (state == gbn_pkg::ST_LOAD) begin
        queue_read <= qnext(queue_read);
        queue_fill <= queue_fill - QF'(1);
      end
      if (state == gbn_pkg::ST_SEND && out_fire) begin
        win_next      <= wnext(win_next);
        win_fill      <= win_fill + WF'(1);
        next_sequence <= next_sequence + 32'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    32'(win_fill) <= WINDOW_MAX) else $error("window overfilled");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    32'(queue_fill) <= QUEUE_DEPTH) else $error("queue overfilled");
  a_send_start: assert property (@(posedge clk) disable iff (rst)
    (out_fire && action == gbn_pkg::ACT_START) |=> timer_running)
    else $error("timer flag not set after start");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during output");
`endif

endmodule
